@@ sv/urlpd_pkg.sv @@
// ----------------------------------------------------------------------------
// urlpd_pkg
// Shared types, character constants and helper functions for the URL
// percent-escape decoder.
// ----------------------------------------------------------------------------
package urlpd_pkg;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] SEMI_CHAR  = 8'h3B;
    localparam logic [7:0] COMMA_CHAR = 8'h2C;
    localparam logic [7:0] QUEST_CHAR = 8'h3F;
    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] AT_CHAR    = 8'h40;
    localparam logic [7:0] AMP_CHAR   = 8'h26;
    localparam logic [7:0] EQ_CHAR    = 8'h3D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] DOLL_CHAR  = 8'h24;
    localparam logic [7:0] HASH_CHAR  = 8'h23;

    localparam int unsigned GRP_BYTES = 3;
    localparam int unsigned CNT_W     = 2;

    localparam logic [2:0] REG_IDX_DECODE_RESERVED = 3'd0;
    localparam logic       DECODE_RESERVED_RESET   = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HIGH = 2'd2
    } t_phase;

    typedef struct packed {
        logic [GRP_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
        logic                      last;
    } t_group;

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [4:0] res;
        res = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            res = {1'b1, 4'(ch - 8'h30)};
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            res = {1'b1, 4'(ch - 8'h37)};
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            res = {1'b1, 4'(ch - 8'h57)};
        end
        return res;
    endfunction

    function automatic logic is_reserved(input logic [7:0] ch);
        return (ch == SEMI_CHAR)  || (ch == COMMA_CHAR) || (ch == QUEST_CHAR) ||
               (ch == COLON_CHAR) || (ch == AT_CHAR)    || (ch == AMP_CHAR)   ||
               (ch == EQ_CHAR)    || (ch == PLUS_CHAR)  || (ch == DOLL_CHAR)  ||
               (ch == HASH_CHAR);
    endfunction

endpackage

@@ sv/urlpd_core.sv @@
// ----------------------------------------------------------------------------
// urlpd_core
// Input register, escape state and decode logic. Each request turns into a
// group of zero to three output bytes handed to the emitter.
// ----------------------------------------------------------------------------
module urlpd_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_in_last,
    input  logic                  i_decode_reserved,
    input  logic                  i_grp_ready,
    output logic                  o_grp_valid,
    output urlpd_pkg::t_group     o_grp
);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    urlpd_pkg::t_phase r_phase;
    urlpd_pkg::t_phase n_phase;
    logic [7:0]        r_held;
    logic [7:0]        n_held;
    logic              adv;
    logic [4:0]        hi_hex;
    logic [4:0]        lo_hex;
    logic [7:0]        dec;
    logic              raw;
    urlpd_pkg::t_group grp;

    assign adv        = r_in_vld && i_grp_ready;
    assign o_in_ready = !r_in_vld || i_grp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= urlpd_pkg::PH_IDLE;
            r_held  <= 8'h00;
        end else if (adv) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    assign hi_hex = urlpd_pkg::hex_digit(r_held);
    assign lo_hex = urlpd_pkg::hex_digit(r_in_byte);
    assign dec    = {hi_hex[3:0], lo_hex[3:0]};
    assign raw    = !(hi_hex[4] && lo_hex[4]) ||
                    (!i_decode_reserved && urlpd_pkg::is_reserved(dec));

    always_comb begin
        n_phase    = urlpd_pkg::PH_IDLE;
        n_held     = r_held;
        grp.bytes  = '0;
        grp.cnt    = 2'd0;
        grp.last   = r_in_last;
        unique case (r_phase)
            urlpd_pkg::PH_PCT: begin
                if (r_in_last) begin
                    grp.bytes[0] = urlpd_pkg::PCT_CHAR;
                    grp.bytes[1] = r_in_byte;
                    grp.cnt      = 2'd2;
                end else begin
                    n_held  = r_in_byte;
                    n_phase = urlpd_pkg::PH_HIGH;
                end
            end
            urlpd_pkg::PH_HIGH: begin
                if (raw) begin
                    grp.bytes[0] = urlpd_pkg::PCT_CHAR;
                    grp.bytes[1] = r_held;
                    grp.bytes[2] = r_in_byte;
                    grp.cnt      = 2'd3;
                end else begin
                    grp.bytes[0] = dec;
                    grp.cnt      = 2'd1;
                end
            end
            default: begin
                if (r_in_byte == urlpd_pkg::PCT_CHAR && !r_in_last) begin
                    n_phase = urlpd_pkg::PH_PCT;
                end else begin
                    grp.bytes[0] = r_in_byte;
                    grp.cnt      = 2'd1;
                end
            end
        endcase
    end

    assign o_grp       = grp;
    assign o_grp_valid = adv && (grp.cnt != 2'd0);

endmodule

@@ sv/urlpd_emit.sv @@
// ----------------------------------------------------------------------------
// urlpd_emit
// Result register: holds one decoded group and shifts it out one byte per
// output request.
// ----------------------------------------------------------------------------
module urlpd_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_grp_valid,
    input  urlpd_pkg::t_group i_grp,
    output logic              o_grp_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_out_last
);

    logic [urlpd_pkg::GRP_BYTES-1:0][7:0] r_bytes;
    logic [urlpd_pkg::CNT_W-1:0]          r_cnt;
    logic                                 r_last;
    logic                                 take;
    logic                                 load;

    assign take        = (r_cnt != 2'd0) && i_out_ready;
    assign o_grp_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);
    assign load        = i_grp_valid && o_grp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (load) begin
            r_cnt <= i_grp.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= i_grp.bytes;
            r_last  <= i_grp.last;
        end else if (take) begin
            r_bytes <= {8'h00, r_bytes[2:1]};
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_byte  = r_bytes[0];
    assign o_out_last  = r_last && (r_cnt == 2'd1);

endmodule

@@ sv/url_percent_decoder_top.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder_top
// Streaming percent-escape decoder with an APB register for reserved
// character handling.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_ready   i_in_byte, i_in_last
//   output    out        o_out_valid / i_out_ready o_out_byte, o_out_last
//   config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One input byte per cycle while the result register can take each group; the
// first result byte of a request is offered once it has passed the input and
// result registers. A group of two or three bytes (raw or truncated escape)
// holds the result register until shifted out; the input side stalls meanwhile.
// Synchronous active-low reset clears the escape state and both handshakes.
// Input and output stalls propagate through one input and one result register.
// ----------------------------------------------------------------------------
module url_percent_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              r_decode_reserved;
    logic              cfg_sel;
    logic              grp_ready;
    logic              grp_valid;
    urlpd_pkg::t_group grp;

    assign pready  = 1'b1;
    assign cfg_sel = ({paddr[2], 2'b00} == urlpd_pkg::REG_IDX_DECODE_RESERVED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_reserved <= urlpd_pkg::DECODE_RESERVED_RESET;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_decode_reserved <= pwdata[0];
        end
    end

    assign prdata = cfg_sel ? {31'd0, r_decode_reserved} : 32'd0;

    urlpd_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_in_byte         (i_in_byte),
        .i_in_last         (i_in_last),
        .i_decode_reserved (r_decode_reserved),
        .i_grp_ready       (grp_ready),
        .o_grp_valid       (grp_valid),
        .o_grp             (grp)
    );

    urlpd_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (grp_valid),
        .i_grp       (grp),
        .o_grp_ready (grp_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule

@@ tb/sv/url_percent_decoder_top_test.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder_top_test
// Self-checking testbench for the URL percent-escape decoder. Byte strings are
// driven over the valid/ready input channel with bursty timing while the
// output side stalls on its own pattern. Every accepted request is run through
// a local decoder model and each output byte is compared with the oldest
// expected byte. The reserved-character register is written over APB between
// phases, including an ignored out-of-range write and writes with noisy upper
// bits.
// ----------------------------------------------------------------------------
module url_percent_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] t_text[$];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_byte;

    localparam logic [2:0] ADDR_DECODE_RESERVED =
        3'(4 * urlpd_pkg::REG_IDX_DECODE_RESERVED);
    localparam logic [2:0] ADDR_UNMAPPED        = 3'd4;
    localparam int         DRAIN_CYCLES         = 8;
    localparam int         RANDOM_ITEMS         = 140;
    localparam logic [7:0] RESERVED_SET [10] = '{
        urlpd_pkg::SEMI_CHAR, urlpd_pkg::COMMA_CHAR, urlpd_pkg::QUEST_CHAR,
        urlpd_pkg::COLON_CHAR, urlpd_pkg::AT_CHAR, urlpd_pkg::AMP_CHAR,
        urlpd_pkg::EQ_CHAR, urlpd_pkg::PLUS_CHAR, urlpd_pkg::DOLL_CHAR,
        urlpd_pkg::HASH_CHAR
    };

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        in_valid    = 1'b0;
    logic        o_in_ready;
    logic [7:0]  in_byte     = 8'h00;
    logic        in_last     = 1'b0;
    logic        o_out_valid;
    logic        out_ready   = 1'b1;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = 3'd0;
    logic [31:0] pwdata      = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    t_out_byte         decoded_q[$];
    urlpd_pkg::t_phase esc_phase       = urlpd_pkg::PH_IDLE;
    logic [7:0]        held_digit      = 8'h00;
    logic              decode_reserved = urlpd_pkg::DECODE_RESERVED_RESET;

    int          n_requests  = 0;
    int          n_checked   = 0;
    int          n_writes    = 0;
    int          n_fail      = 0;
    int          burst_left  = 0;
    logic [9:0]  stall_cyc   = 10'd0;

    url_percent_decoder_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (in_byte),
        .i_in_last   (in_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #1ms;
        $display("simulation failed");
        $finish;
    end

    // Receiver: free flow, coin-flip stalls, one-in-four, mostly ready.
    always @(negedge i_clk) begin
        stall_cyc <= stall_cyc + 10'd1;
        case (stall_cyc[9:8])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= 1'($urandom_range(0, 1));
            2'd2: out_ready <= (stall_cyc[1:0] == 2'd0);
            default: out_ready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    function automatic int hex_nibble(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
        if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
        if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
        if (n < 4'd10) return 8'("0") + 8'(n);
        return (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
    endfunction

    function automatic t_text text_of(input string s);
        t_text txt;
        for (int i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
        return txt;
    endfunction

    task automatic note_failure(input string msg);
        n_fail++;
        if (n_fail <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    task automatic push_decoded(input logic [7:0] b, input logic l);
        decoded_q.insert(decoded_q.size(), t_out_byte'{b, l});
    endtask

    task automatic decode_request(input logic [7:0] b, input logic l);
        int         hi;
        int         lo;
        logic       raw;
        logic [7:0] value;
        case (esc_phase)
            urlpd_pkg::PH_PCT: begin
                if (l) begin
                    push_decoded(urlpd_pkg::PCT_CHAR, 1'b0);
                    push_decoded(b, 1'b1);
                    esc_phase = urlpd_pkg::PH_IDLE;
                end else begin
                    held_digit = b;
                    esc_phase  = urlpd_pkg::PH_HIGH;
                end
            end
            urlpd_pkg::PH_HIGH: begin
                hi    = hex_nibble(held_digit);
                lo    = hex_nibble(b);
                raw   = 1'b1;
                value = 8'h00;
                if (hi >= 0 && lo >= 0) begin
                    value = 8'((hi << 4) | lo);
                    raw   = !decode_reserved && (value inside {RESERVED_SET});
                end
                if (raw) begin
                    push_decoded(urlpd_pkg::PCT_CHAR, 1'b0);
                    push_decoded(held_digit, 1'b0);
                    push_decoded(b, l);
                end else begin
                    push_decoded(value, l);
                end
                esc_phase = urlpd_pkg::PH_IDLE;
            end
            default: begin
                if (b == urlpd_pkg::PCT_CHAR && !l) begin
                    esc_phase = urlpd_pkg::PH_PCT;
                end else begin
                    push_decoded(b, l);
                    esc_phase = urlpd_pkg::PH_IDLE;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_byte want;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready && paddr == ADDR_DECODE_RESERVED) begin
                decode_reserved = pwdata[0];
            end
            if (in_valid && o_in_ready) begin
                decode_request(in_byte, in_last);
                n_requests++;
            end
            if (o_out_valid && out_ready) begin
                n_checked++;
                if (decoded_q.size() == 0) begin
                    note_failure($sformatf("unexpected byte %h last %b",
                                           o_out_byte, o_out_last));
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out_byte !== want.data || o_out_last !== want.last) begin
                        note_failure($sformatf("byte %h last %b, expected byte %h last %b",
                                               o_out_byte, o_out_last, want.data, want.last));
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= l;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_text(input t_text txt);
        for (int i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        wait_idle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_writes++;
    endtask

    task automatic set_decode_reserved(input logic value);
        apb_write(ADDR_DECODE_RESERVED, {31'($urandom), value});
    endtask

    function automatic t_text random_text();
        t_text      txt;
        int         n_tokens;
        logic [7:0] value;
        logic [7:0] b1;
        logic [7:0] b2;
        n_tokens = $urandom_range(1, 8);
        for (int t = 0; t < n_tokens; t++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: txt.insert(txt.size(), 8'($urandom));
                3:       txt.insert(txt.size(), 8'($urandom_range(32, 126)));
                4, 5, 6: begin
                    value = ($urandom_range(0, 3) == 0) ? RESERVED_SET[$urandom_range(0, 9)]
                                                         : 8'($urandom);
                    txt.insert(txt.size(), urlpd_pkg::PCT_CHAR);
                    txt.insert(txt.size(), hex_char(value[7:4], 1'($urandom)));
                    txt.insert(txt.size(), hex_char(value[3:0], 1'($urandom)));
                end
                7, 8: begin
                    b1 = ($urandom_range(0, 1) == 0) ? hex_char(4'($urandom), 1'($urandom))
                                                     : 8'($urandom);
                    b2 = ($urandom_range(0, 1) == 0) ? hex_char(4'($urandom), 1'($urandom))
                                                     : 8'($urandom);
                    if (hex_nibble(b1) >= 0 && hex_nibble(b2) >= 0) begin
                        if ($urandom_range(0, 1) == 0) b1 = "g";
                        else b2 = "Z";
                    end
                    txt.insert(txt.size(), urlpd_pkg::PCT_CHAR);
                    txt.insert(txt.size(), b1);
                    txt.insert(txt.size(), b2);
                end
                default: begin
                    txt.insert(txt.size(), urlpd_pkg::PCT_CHAR);
                    txt.insert(txt.size(), urlpd_pkg::PCT_CHAR);
                end
            endcase
        end
        if ($urandom_range(0, 6) == 0) begin
            txt.insert(txt.size(), urlpd_pkg::PCT_CHAR);
            if ($urandom_range(0, 1) == 0) begin
                txt.insert(txt.size(), hex_char(4'($urandom), 1'($urandom)));
            end
        end
        return txt;
    endfunction

    task automatic run_random_strings(input int n_items);
        t_text txt;
        int    sent;
        sent = 0;
        while (sent < n_items) begin
            txt = random_text();
            send_text(txt);
            sent += txt.size();
        end
    endtask

    task automatic test_reset_mode();
        send_text('{8'h00, 8'hFF});
        send_text(text_of("%"));
        send_text(text_of("%0f%aF%2G%g2%3B"));
        send_text(text_of("%4"));
    endtask

    task automatic test_reserved_kept();
        set_decode_reserved(1'b0);
        send_text(text_of("%2c"));
    endtask

    task automatic test_unmapped_write();
        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        send_text(text_of("%3B"));
    endtask

    task automatic test_random_traffic();
        set_decode_reserved(1'b1);
        run_random_strings(RANDOM_ITEMS);
        set_decode_reserved(1'b0);
        run_random_strings(RANDOM_ITEMS);
        set_decode_reserved(1'b1);
        run_random_strings(RANDOM_ITEMS);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_mode();
        test_reserved_kept();
        test_unmapped_write();
        test_random_traffic();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (decoded_q.size() != 0) note_failure("expected bytes never arrived");

        $display("%0d requests decoded into %0d output bytes, %0d register writes,",
                 n_requests, n_checked, n_writes);
        $display("reserved decoding on and off, bursty input, stalled output");
        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ url_percent_decoder_top.f @@
sv/urlpd_pkg.sv
sv/urlpd_core.sv
sv/urlpd_emit.sv
sv/url_percent_decoder_top.sv
tb/sv/url_percent_decoder_top_test.sv
